>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("never-condition hit");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

>>> src/gn2_pkg.sv
package gn2_pkg;

  // command codes on the input port
  localparam logic [1:0] CMD_PERM = 2'd0;
  localparam logic [1:0] CMD_GRAD = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  typedef enum logic [1:0] {
    OP_PERM = 2'd0,
    OP_GRAD = 2'd1,
    OP_EVAL = 2'd2
  } op_t;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 7;
  localparam int PERM_W  = 7;
  localparam int GRAD_W  = 16;
  localparam int COORD_W = 24;
  localparam int NOISE_W = 16;
  localparam int W16_W   = 17;   // blend weight, 0..65536

  localparam int NOISE_MAX = 32767;
  localparam int NOISE_MIN = -32768;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = 2;
  localparam int IQ_CNT_W = 3;

  localparam int OQ_DEPTH = 16;
  localparam int OQ_PTR_W = 4;
  localparam int OQ_CNT_W = 5;

  typedef struct packed {
    logic eval_issue;   // evaluate entered the pipeline
    logic load_issue;   // table write done this cycle
    logic rd_busy;      // table reads still pending in the pipe
  } back_stat_t;

endpackage

>>> src/gn2_front.sv
module gn2_front #(
  parameter int IW = 7,
  parameter int FB = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [gn2_pkg::CMD_W-1:0]          command,
  input  logic [gn2_pkg::IDX_W-1:0]          table_index,
  input  logic [gn2_pkg::PERM_W-1:0]         perm_value,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  grad_x_value,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  grad_y_value,
  input  logic signed [gn2_pkg::COORD_W-1:0] coord_x,
  input  logic signed [gn2_pkg::COORD_W-1:0] coord_y,
  output logic                               hd_vld,
  output gn2_pkg::op_t                       hd_op,
  output logic [IW-1:0]                      hd_idx,
  output logic [gn2_pkg::PERM_W-1:0]         hd_perm,
  output logic signed [gn2_pkg::GRAD_W-1:0]  hd_gx,
  output logic signed [gn2_pkg::GRAD_W-1:0]  hd_gy,
  output logic [FB-1:0]                      hd_tx,
  output logic [FB-1:0]                      hd_ty,
  output logic [IW-1:0]                      hd_cx0,
  output logic [IW-1:0]                      hd_cx1,
  output logic [IW-1:0]                      hd_cy0,
  output logic [IW-1:0]                      hd_cy1,
  input  logic                               hd_take
);

  localparam int XW = (IW > gn2_pkg::IDX_W) ? IW : gn2_pkg::IDX_W;
  localparam int EW = 2 + IW + gn2_pkg::PERM_W + 2 * gn2_pkg::GRAD_W + 2 * FB + 4 * IW;

  logic [EW-1:0]                   q_r [gn2_pkg::IQ_DEPTH];
  logic [gn2_pkg::IQ_PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [gn2_pkg::IQ_CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                            enq;
  gn2_pkg::op_t                    op;
  logic [XW-1:0]                   idx_ext;
  logic signed [gn2_pkg::COORD_W-1:0] cellx, celly;
  logic [IW-1:0]                   cx0, cy0;
  logic [EW-1:0]                   enq_word;
  logic [1:0]                      op_bits;

  // classify: command 3 is swallowed
  always_comb begin
    case (command)
      gn2_pkg::CMD_PERM: op = gn2_pkg::OP_PERM;
      gn2_pkg::CMD_GRAD: op = gn2_pkg::OP_GRAD;
      default:           op = gn2_pkg::OP_EVAL;
    endcase
  end

  assign full = (cnt_r == gn2_pkg::IQ_CNT_W'(gn2_pkg::IQ_DEPTH));
  assign enq  = push && !full &&
                (command inside {gn2_pkg::CMD_PERM, gn2_pkg::CMD_GRAD, gn2_pkg::CMD_EVAL});

  // floor and wrap of the cell are a shift and a mask
  assign idx_ext = XW'(table_index);
  assign cellx   = coord_x >>> FB;
  assign celly   = coord_y >>> FB;
  assign cx0     = cellx[IW-1:0];
  assign cy0     = celly[IW-1:0];

  assign enq_word = {op, idx_ext[IW-1:0], perm_value, grad_x_value, grad_y_value,
                     coord_x[FB-1:0], coord_y[FB-1:0],
                     cx0, cx0 + IW'(1), cy0, cy0 + IW'(1)};

  assign {op_bits, hd_idx, hd_perm, hd_gx, hd_gy, hd_tx, hd_ty,
          hd_cx0, hd_cx1, hd_cy0, hd_cy1} = q_r[rp_r];
  assign hd_op  = gn2_pkg::op_t'(op_bits);
  assign hd_vld = (cnt_r != '0);

  always_comb begin
    wp_nxt  = enq ? wp_r + gn2_pkg::IQ_PTR_W'(1) : wp_r;
    rp_nxt  = hd_take ? rp_r + gn2_pkg::IQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + gn2_pkg::IQ_CNT_W'(enq) - gn2_pkg::IQ_CNT_W'(hd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= enq_word;
    end
  end

endmodule

>>> src/gn2_back.sv
module gn2_back #(
  parameter int IW = 7,
  parameter int FB = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               hd_vld,
  input  gn2_pkg::op_t                       hd_op,
  input  logic [IW-1:0]                      hd_idx,
  input  logic [gn2_pkg::PERM_W-1:0]         hd_perm,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  hd_gx,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  hd_gy,
  input  logic [FB-1:0]                      hd_tx,
  input  logic [FB-1:0]                      hd_ty,
  input  logic [IW-1:0]                      hd_cx0,
  input  logic [IW-1:0]                      hd_cx1,
  input  logic [IW-1:0]                      hd_cy0,
  input  logic [IW-1:0]                      hd_cy1,
  output logic                               hd_take,
  input  logic                               can_eval,
  output logic                               res_vld,
  output logic signed [gn2_pkg::NOISE_W-1:0] res_noise,
  output gn2_pkg::back_stat_t                stat
);

  localparam int TS  = 1 << IW;
  localparam int PW7 = gn2_pkg::PERM_W;
  localparam int GW  = gn2_pkg::GRAD_W;
  localparam int SW  = (IW > PW7) ? IW : PW7;
  localparam int DW  = GW + FB + 2;                 // dot product
  localparam int PW  = DW + 1 + gn2_pkg::W16_W + 1; // x blend product
  localparam int BW  = DW + 2;                      // blended value
  localparam int YW  = BW + 1 + gn2_pkg::W16_W + 1; // y blend product
  localparam int VW  = BW + 1;
  localparam int WW  = 3 * FB + 2;                  // raw weight
  localparam int SH  = 3 * FB;
  localparam int SH_DN = (SH > 16) ? SH - 16 : 0;
  localparam int SH_UP = (SH < 16) ? 16 - SH : 0;
  localparam longint RND = (SH > 16) ? (longint'(1) << (SH - 17)) : 0;
  localparam logic signed [VW-1:0] SAT_HI = VW'(gn2_pkg::NOISE_MAX);
  localparam logic signed [VW-1:0] SAT_LO = VW'(gn2_pkg::NOISE_MIN);

  // table copies: every write goes to all copies of its table, each copy serves two reads
  logic [PW7-1:0]        perm_a [TS];
  logic [PW7-1:0]        perm_b [TS];
  logic [PW7-1:0]        perm_c [TS];
  logic signed [GW-1:0]  gx_a [TS];
  logic signed [GW-1:0]  gx_b [TS];
  logic signed [GW-1:0]  gy_a [TS];
  logic signed [GW-1:0]  gy_b [TS];

  logic wr_perm, wr_grad, iss;

  logic                 vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r, vld8_r;
  logic [FB-1:0]        tx1_r, ty1_r, tx2_r, ty2_r, tx3_r, ty3_r;
  logic [IW-1:0]        cy0_1_r, cy1_1_r;
  logic [PW7-1:0]       pa0_r, pa1_r;
  logic [2*FB-1:0]      txx2_r, tyy2_r;
  logic [IW-1:0]        h00, h01, h10, h11;
  logic [PW7-1:0]       q00_r, q01_r, q10_r, q11_r;
  logic [WW-1:0]        wxr3_r, wyr3_r;
  logic signed [GW-1:0] gx00_r, gx01_r, gx10_r, gx11_r;
  logic signed [GW-1:0] gy00_r, gy01_r, gy10_r, gy11_r;
  logic [gn2_pkg::W16_W-1:0] wx4_r, wy4_r, wy5_r, wy6_r;
  logic signed [DW-1:0] d00_r, d01_r, d10_r, d11_r, a0_5_r, a1_5_r;
  logic signed [PW-1:0] p0_5_r, p1_5_r;
  logic signed [BW-1:0] v0_6_r, v1_6_r, v0_7_r;
  logic signed [YW-1:0] py7_r;
  logic signed [VW-1:0] v8_r;

  logic [FB+1:0]        mx, my;
  logic signed [FB:0]   dx0, dx1, dy0, dy1;
  logic signed [DW:0]   df0, df1;
  logic signed [PW-1:0] p0, p1, r0, r1;
  logic signed [BW:0]   dfy;
  logic signed [YW-1:0] py, ry;
  logic signed [VW-1:0] vr;

  function automatic logic [IW-1:0] hash_addr(input logic [IW-1:0] cy,
                                               input logic [PW7-1:0] a);
    logic [SW-1:0] s;
    s = SW'(cy) + SW'(a);
    return s[IW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] dotp(input logic signed [GW-1:0] gx,
                                                input logic signed [GW-1:0] gy,
                                                input logic signed [FB:0]   dx,
                                                input logic signed [FB:0]   dy);
    logic signed [GW+FB:0] px, pyv;
    px  = gx * dx;
    pyv = gy * dy;
    return DW'(px) + DW'(pyv);
  endfunction

  // weight at 2^(3F) rounded half up to Q1.16
  function automatic logic [gn2_pkg::W16_W-1:0] w16_of(input logic [WW-1:0] w);
    logic [WW-1:0] t;
    t = '0;
    if (SH > 16) begin
      t = (w + WW'(RND)) >> SH_DN;
      return gn2_pkg::W16_W'(t);
    end else if (SH == 16) begin
      return gn2_pkg::W16_W'(w);
    end else begin
      return gn2_pkg::W16_W'(gn2_pkg::W16_W'(w) << SH_UP);
    end
  endfunction

  // issue: an evaluate waits for a credit; a load waits until earlier evaluates have done their table reads
  always_comb begin
    case (hd_op)
      gn2_pkg::OP_EVAL: hd_take = hd_vld && can_eval;
      default:          hd_take = hd_vld && !(vld1_r || vld2_r);
    endcase
    wr_perm = hd_take && (hd_op == gn2_pkg::OP_PERM);
    wr_grad = hd_take && (hd_op == gn2_pkg::OP_GRAD);
    iss     = hd_take && (hd_op == gn2_pkg::OP_EVAL);
  end

  assign stat.eval_issue = iss;
  assign stat.load_issue = wr_perm || wr_grad;
  assign stat.rd_busy    = vld1_r || vld2_r;

  always_ff @(posedge clk) begin
    if (wr_perm) begin
      perm_a[hd_idx] <= hd_perm;
      perm_b[hd_idx] <= hd_perm;
      perm_c[hd_idx] <= hd_perm;
    end
    if (wr_grad) begin
      gx_a[hd_idx] <= hd_gx;
      gx_b[hd_idx] <= hd_gx;
      gy_a[hd_idx] <= hd_gy;
      gy_b[hd_idx] <= hd_gy;
    end
  end

  // stage 0 -> 1: first hash level
  always_ff @(posedge clk) begin
    pa0_r   <= perm_a[hd_cx0];
    pa1_r   <= perm_a[hd_cx1];
    tx1_r   <= hd_tx;
    ty1_r   <= hd_ty;
    cy0_1_r <= hd_cy0;
    cy1_1_r <= hd_cy1;
  end

  // stage 1 -> 2: second hash level, fraction squares
  always_comb begin
    h00 = hash_addr(cy0_1_r, pa0_r);
    h01 = hash_addr(cy0_1_r, pa1_r);
    h10 = hash_addr(cy1_1_r, pa0_r);
    h11 = hash_addr(cy1_1_r, pa1_r);
  end

  always_ff @(posedge clk) begin
    q00_r  <= perm_b[h00];
    q01_r  <= perm_b[h01];
    q10_r  <= perm_c[h10];
    q11_r  <= perm_c[h11];
    txx2_r <= tx1_r * tx1_r;
    tyy2_r <= ty1_r * ty1_r;
    tx2_r  <= tx1_r;
    ty2_r  <= ty1_r;
  end

  // stage 2 -> 3: gradient fetch, raw weight (3*one - 2t) * t^2
  always_comb begin
    mx = (FB + 2)'(3 << FB) - (FB + 2)'({tx2_r, 1'b0});
    my = (FB + 2)'(3 << FB) - (FB + 2)'({ty2_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    gx00_r <= gx_a[q00_r];
    gx01_r <= gx_a[q01_r];
    gx10_r <= gx_b[q10_r];
    gx11_r <= gx_b[q11_r];
    gy00_r <= gy_a[q00_r];
    gy01_r <= gy_a[q01_r];
    gy10_r <= gy_b[q10_r];
    gy11_r <= gy_b[q11_r];
    wxr3_r <= WW'(mx) * WW'(txx2_r);
    wyr3_r <= WW'(my) * WW'(tyy2_r);
    tx3_r  <= tx2_r;
    ty3_r  <= ty2_r;
  end

  // stage 3 -> 4: corner dot products; t - one is just the sign bit set
  always_comb begin
    dx0 = {1'b0, tx3_r};
    dx1 = {1'b1, tx3_r};
    dy0 = {1'b0, ty3_r};
    dy1 = {1'b1, ty3_r};
  end

  always_ff @(posedge clk) begin
    d00_r <= dotp(gx00_r, gy00_r, dx0, dy0);
    d01_r <= dotp(gx01_r, gy01_r, dx1, dy0);
    d10_r <= dotp(gx10_r, gy10_r, dx0, dy1);
    d11_r <= dotp(gx11_r, gy11_r, dx1, dy1);
    wx4_r <= w16_of(wxr3_r);
    wy4_r <= w16_of(wyr3_r);
  end

  // stage 4 -> 5: x blend product
  always_comb begin
    df0 = (DW + 1)'(d00_r) - (DW + 1)'(d01_r);
    df1 = (DW + 1)'(d10_r) - (DW + 1)'(d11_r);
    p0  = PW'(signed'({1'b0, wx4_r})) * PW'(df0);
    p1  = PW'(signed'({1'b0, wx4_r})) * PW'(df1);
  end

  always_ff @(posedge clk) begin
    p0_5_r <= p0;
    p1_5_r <= p1;
    a0_5_r <= d00_r;
    a1_5_r <= d10_r;
    wy5_r  <= wy4_r;
  end

  // stage 5 -> 6: x blend result
  always_comb begin
    r0 = (p0_5_r + PW'(1 << 15)) >>> 16;
    r1 = (p1_5_r + PW'(1 << 15)) >>> 16;
  end

  always_ff @(posedge clk) begin
    v0_6_r <= BW'(a0_5_r) - BW'(r0);
    v1_6_r <= BW'(a1_5_r) - BW'(r1);
    wy6_r  <= wy5_r;
  end

  // stage 6 -> 7: y blend product
  always_comb begin
    dfy = (BW + 1)'(v0_6_r) - (BW + 1)'(v1_6_r);
    py  = YW'(signed'({1'b0, wy6_r})) * YW'(dfy);
  end

  always_ff @(posedge clk) begin
    py7_r  <= py;
    v0_7_r <= v0_6_r;
  end

  // stage 7 -> 8: y blend result
  assign ry = (py7_r + YW'(1 << 15)) >>> 16;

  always_ff @(posedge clk) begin
    v8_r <= VW'(v0_7_r) - VW'(ry);
  end

  // drop fraction bits, saturate to Q2.14
  always_comb begin
    vr = (v8_r + VW'(1 << (FB - 1))) >>> FB;
    if (vr > SAT_HI) begin
      res_noise = gn2_pkg::NOISE_W'(gn2_pkg::NOISE_MAX);
    end else if (vr < SAT_LO) begin
      res_noise = gn2_pkg::NOISE_W'(gn2_pkg::NOISE_MIN);
    end else begin
      res_noise = vr[gn2_pkg::NOISE_W-1:0];
    end
  end

  assign res_vld = vld8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else begin
      vld1_r <= iss;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
    end
  end

endmodule

>>> src/gn2_outq.sv
module gn2_outq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr,
  input  logic signed [gn2_pkg::NOISE_W-1:0] wdata,
  output logic                               full,
  output logic                               empty,
  input  logic                               rd,
  output logic signed [gn2_pkg::NOISE_W-1:0] rdata
);

  logic signed [gn2_pkg::NOISE_W-1:0] q_r [gn2_pkg::OQ_DEPTH];
  logic [gn2_pkg::OQ_PTR_W-1:0]       wp_r, rp_r;
  logic [gn2_pkg::OQ_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                               do_rd;

  assign full  = (cnt_r == gn2_pkg::OQ_CNT_W'(gn2_pkg::OQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_rd = rd && !empty;
  assign rdata = q_r[rp_r];
  assign cnt_nxt = cnt_r + gn2_pkg::OQ_CNT_W'(wr) - gn2_pkg::OQ_CNT_W'(do_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + gn2_pkg::OQ_PTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + gn2_pkg::OQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= wdata;
    end
  end

endmodule

>>> src/gradient_noise_2d.sv
// Path: an evaluate word accepted into the input queue passes 8 pipeline stages and
//   1 result queue stage before it shows on out_*.
// Throughput: one word per cycle unless stalled; an evaluate waits for a credit and a
//   load right behind an evaluate waits while the table reads of that evaluate drain.
// Reset: synchronous, active low; clears queues and pipeline valids, and refills the
//   credits to the queue depth. Tables are not cleared and must be loaded before use.
`include "assert_macros.svh"

module gradient_noise_2d #(
  parameter int TABLE_SIZE      = 128,  // power of two
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [gn2_pkg::CMD_W-1:0]          in_command,
  input  logic [gn2_pkg::IDX_W-1:0]          in_table_index,
  input  logic [gn2_pkg::PERM_W-1:0]         in_perm_value,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  in_grad_x_value,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  in_grad_y_value,
  input  logic signed [gn2_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [gn2_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [gn2_pkg::NOISE_W-1:0] out_noise_value
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int FB = COORD_FRAC_BITS;

  // front -> back queue head
  logic                              hd_vld, hd_take;
  gn2_pkg::op_t                      hd_op;
  logic [IW-1:0]                     hd_idx, hd_cx0, hd_cx1, hd_cy0, hd_cy1;
  logic [gn2_pkg::PERM_W-1:0]        hd_perm;
  logic signed [gn2_pkg::GRAD_W-1:0] hd_gx, hd_gy;
  logic [FB-1:0]                     hd_tx, hd_ty;

  logic                               res_vld, oq_full, pop_ok;
  logic signed [gn2_pkg::NOISE_W-1:0] res_noise;
  gn2_pkg::back_stat_t                stat;

  // Credits: one per free result queue slot, counting words still in the
  // pipeline as taken, so the pipeline never has to stall.
  logic [gn2_pkg::OQ_CNT_W-1:0] cred_r, cred_nxt;

  gn2_front #(.IW(IW), .FB(FB)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .command      (in_command),
    .table_index  (in_table_index),
    .perm_value   (in_perm_value),
    .grad_x_value (in_grad_x_value),
    .grad_y_value (in_grad_y_value),
    .coord_x      (in_coord_x),
    .coord_y      (in_coord_y),
    .hd_vld       (hd_vld),
    .hd_op        (hd_op),
    .hd_idx       (hd_idx),
    .hd_perm      (hd_perm),
    .hd_gx        (hd_gx),
    .hd_gy        (hd_gy),
    .hd_tx        (hd_tx),
    .hd_ty        (hd_ty),
    .hd_cx0       (hd_cx0),
    .hd_cx1       (hd_cx1),
    .hd_cy0       (hd_cy0),
    .hd_cy1       (hd_cy1),
    .hd_take      (hd_take)
  );

  gn2_back #(.IW(IW), .FB(FB)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd_vld    (hd_vld),
    .hd_op     (hd_op),
    .hd_idx    (hd_idx),
    .hd_perm   (hd_perm),
    .hd_gx     (hd_gx),
    .hd_gy     (hd_gy),
    .hd_tx     (hd_tx),
    .hd_ty     (hd_ty),
    .hd_cx0    (hd_cx0),
    .hd_cx1    (hd_cx1),
    .hd_cy0    (hd_cy0),
    .hd_cy1    (hd_cy1),
    .hd_take   (hd_take),
    .can_eval  (cred_r != '0),
    .res_vld   (res_vld),
    .res_noise (res_noise),
    .stat      (stat)
  );

  gn2_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_vld),
    .wdata (res_noise),
    .full  (oq_full),
    .empty (out_empty),
    .rd    (out_pop),
    .rdata (out_noise_value)
  );

  assign pop_ok   = out_pop && !out_empty;
  assign cred_nxt = cred_r - gn2_pkg::OQ_CNT_W'(stat.eval_issue)
                           + gn2_pkg::OQ_CNT_W'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= gn2_pkg::OQ_CNT_W'(gn2_pkg::OQ_DEPTH);
    end else begin
      cred_r <= cred_nxt;
    end
  end

  // result queue must always have room when a result lands
  `ASSERT_NEVER(a_oq_overflow, clk, rst_n, res_vld && oq_full)
  // credits never exceed the queue depth
  `ASSERT_NEVER(a_cred_range, clk, rst_n, cred_r > gn2_pkg::OQ_CNT_W'(gn2_pkg::OQ_DEPTH))
  // a table write never races a pending table read
  `ASSERT_IMPLIES(a_load_quiet, clk, rst_n, stat.load_issue, !stat.rd_busy)

endmodule
